[src/fca_pkg.sv]
// package: widths, register indexes and pipeline control types for the fir filter
`timescale 1ns / 1ps
`default_nettype none

package fca_pkg;

  // field widths
  localparam int ABSC_W      = 32;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int FILT_W      = 36;
  localparam int TAP_CNT_W   = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // coefficient packing: four q2.14 taps per 64-bit word
  localparam int COEF_WORDS     = 4;
  localparam int COEFS_PER_WORD = 4;
  localparam int COEF_TAPS      = COEF_WORDS * COEFS_PER_WORD;
  localparam int COEF_IDX_W     = $clog2(COEF_TAPS);

  // adder tree: sixteen leaves, four groups of four
  localparam int TREE_LEAVES = COEF_TAPS;
  localparam int GROUP_SIZE  = 4;
  localparam int TREE_GROUPS = TREE_LEAVES / GROUP_SIZE;
  localparam int MID_W       = PROD_W + $clog2(GROUP_SIZE);

  // register reset values
  localparam logic [TAP_CNT_W-1:0]  TAP_COUNT_RST = TAP_CNT_W'(1);
  localparam logic [CFG_DATA_W-1:0] COEF_A_RST    = CFG_DATA_W'(16384);
  localparam logic [CFG_DATA_W-1:0] COEF_RST      = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_COEF_A    = 3'd1,
    REG_COEF_B    = 3'd2,
    REG_COEF_C    = 3'd3,
    REG_COEF_D    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic ld_mid;
    logic ld_out;
  } tree_ctrl_t;

endpackage

`default_nettype wire

[src/fca_if.sv]
// interfaces: sample request, result request and register write channels
`timescale 1ns / 1ps
`default_nettype none

interface fca_in_if import fca_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ABSC_W-1:0]   abscissa;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, abscissa, sample, restart, input ready);
  modport sink   (input valid, abscissa, sample, restart, output ready);
endinterface

interface fca_out_if import fca_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FILT_W-1:0] filtered;
  logic signed [ABSC_W-1:0] center_abscissa;

  modport source (output valid, filtered, center_abscissa, input ready);
  modport sink   (input valid, filtered, center_abscissa, output ready);
endinterface

interface fca_cfg_if import fca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/fir_filter_with_centered_abscissa.sv]
// top level: fir filter over (x, y) pairs with window center abscissa
//
//  channel   | modport | request carries                       | accepted when
//  ----------+---------+---------------------------------------+--------------------
//  samples   | sink    | abscissa, sample, restart             | valid && ready
//  results   | source  | filtered, center_abscissa             | valid && ready
//  cfg       | sink    | index (0 tap_count, 1..4 coef words)  | valid && ready
//
//  one sample request per cycle unless a stalled result backs up the pipeline
//  a sample passes the product register in each cell and then the two adder tree levels
//  rst clears the window, fill count, pipeline valids and registers to reset values
//  a stalled result holds in the output register; ready is a combinational chain
//  from the output back to the input, so the input stays ready while any stage has a bubble
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_with_centered_abscissa import fca_pkg::*; #(
  parameter int MAX_TAPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  fca_in_if.sink    samples,
  fca_out_if.source results,
  fca_cfg_if.sink   cfg
);

  localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int FILL_W = $clog2(MAX_TAPS + 1);
  localparam logic [TAP_CNT_W-1:0] MAX_LEN  = TAP_CNT_W'(MAX_TAPS);
  localparam logic [FILL_W-1:0]    FILL_MAX = FILL_W'(MAX_TAPS);

  // configuration registers
  logic [TAP_CNT_W-1:0]  tap_count;
  logic [CFG_DATA_W-1:0] coef_word [COEF_WORDS];

  // window, fill count and pipeline control
  logic [FILL_W-1:0]          fill_count;
  logic [FILL_W-1:0]          fill_next;
  logic [TAP_CNT_W-1:0]       eff_len;
  logic                       emit;
  logic                       accept;
  logic                       v1, v2, v3;
  logic                       ready1, ready2, ready3;
  tree_ctrl_t                 tree_ctrl;

  logic signed [COEF_W-1:0]   coef_tab  [COEF_TAPS];
  logic signed [COEF_W-1:0]   cell_coef [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] win_s     [MAX_TAPS];
  logic signed [ABSC_W-1:0]   win_x     [MAX_TAPS];
  logic signed [ABSC_W-1:0]   x_next    [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] s_in      [MAX_TAPS];
  logic signed [PROD_W-1:0]   cell_prod [MAX_TAPS];
  logic signed [PROD_W-1:0]   leaf      [TREE_LEAVES];

  // center abscissa path
  logic [IDX_W-1:0]           idx_a, idx_b;
  logic signed [ABSC_W:0]     mid_sum;
  logic signed [ABSC_W-1:0]   center1, center2, center3;

  // register writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= TAP_COUNT_RST;
      coef_word[0] <= COEF_A_RST;
      coef_word[1] <= COEF_RST;
      coef_word[2] <= COEF_RST;
      coef_word[3] <= COEF_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_TAP_COUNT: tap_count    <= cfg.data[TAP_CNT_W-1:0];
        REG_COEF_A:    coef_word[0] <= cfg.data;
        REG_COEF_B:    coef_word[1] <= cfg.data;
        REG_COEF_C:    coef_word[2] <= cfg.data;
        REG_COEF_D:    coef_word[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  // window length in use: zero means one, above the cell count means all cells
  always_comb begin
    priority if (tap_count == '0) begin
      eff_len = TAP_CNT_W'(1);
    end else if (tap_count > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = tap_count;
    end
  end

  // unpack the coefficient words, lowest tap in the low bits
  always_comb begin
    for (int t = 0; t < COEF_TAPS; t++) begin
      coef_tab[t] = coef_word[t / COEFS_PER_WORD][(t % COEFS_PER_WORD) * COEF_W +: COEF_W];
    end
  end

  // cell i holds the i-th newest entry; coef 0 goes to the oldest of the window
  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      if (TAP_CNT_W'(i) < eff_len) begin
        cell_coef[i] = coef_tab[COEF_IDX_W'(eff_len - TAP_CNT_W'(1) - TAP_CNT_W'(i))];
      end else begin
        cell_coef[i] = '0;
      end
    end
  end

  // handshake: each stage moves when the next one is free or moving
  assign ready3        = !v3 || results.ready;
  assign ready2        = !v2 || ready3;
  assign ready1        = !v1 || ready2;
  assign samples.ready = ready1;
  assign accept        = samples.valid && ready1;

  assign tree_ctrl.ld_mid = v1 && ready2;
  assign tree_ctrl.ld_out = v2 && ready3;

  // fill count saturates at the cell count; restart makes this sample the first
  always_comb begin
    priority if (samples.restart) begin
      fill_next = FILL_W'(1);
    end else if (fill_count == FILL_MAX) begin
      fill_next = fill_count;
    end else begin
      fill_next = fill_count + FILL_W'(1);
    end
  end

  assign emit = TAP_CNT_W'(fill_next) >= eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_next;
        v1         <= emit;
      end else if (ready2) begin
        v1 <= 1'b0;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  // row of tap cells, each shifting into its neighbor on every accepted sample
  always_comb begin
    s_in[0]   = samples.sample;
    x_next[0] = samples.abscissa;
    for (int i = 1; i < MAX_TAPS; i++) begin
      s_in[i]   = win_s[i-1];
      x_next[i] = win_x[i-1];
    end
  end

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    fca_tap_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (accept),
      .sample_in   (s_in[i]),
      .abscissa_in (x_next[i]),
      .coef        (cell_coef[i]),
      .sample_q    (win_s[i]),
      .abscissa_q  (win_x[i]),
      .product     (cell_prod[i])
    );
  end

  // unused tree leaves stay zero
  always_comb begin
    for (int j = 0; j < TREE_LEAVES; j++) begin
      if (j < MAX_TAPS) begin
        leaf[j] = cell_prod[j];
      end else begin
        leaf[j] = '0;
      end
    end
  end

  fca_sum_tree u_tree (
    .clk  (clk),
    .ctrl (tree_ctrl),
    .prod (leaf),
    .sum  (results.filtered)
  );

  // center: mean of the two middle entries, which coincide for an odd length
  assign idx_a   = IDX_W'((eff_len - TAP_CNT_W'(1)) >> 1);
  assign idx_b   = IDX_W'(eff_len >> 1);
  assign mid_sum = (ABSC_W+1)'(x_next[idx_a]) + (ABSC_W+1)'(x_next[idx_b]);

  always_ff @(posedge clk) begin
    if (accept) begin
      center1 <= mid_sum[ABSC_W:1];
    end
    if (tree_ctrl.ld_mid) begin
      center2 <= center1;
    end
    if (tree_ctrl.ld_out) begin
      center3 <= center2;
    end
  end

  assign results.valid           = v3;
  assign results.center_abscissa = center3;

endmodule

`default_nettype wire

[src/fca_tap_cell.sv]
// one tap cell: holds a window entry, passes it on, multiplies it by its coefficient
`timescale 1ns / 1ps
`default_nettype none

module fca_tap_cell import fca_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic signed [ABSC_W-1:0]   abscissa_in,
  input  logic signed [COEF_W-1:0]   coef,
  output logic signed [SAMPLE_W-1:0] sample_q,
  output logic signed [ABSC_W-1:0]   abscissa_q,
  output logic signed [PROD_W-1:0]   product
);

  logic signed [PROD_W-1:0] mult;

  assign mult = sample_in * coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_q   <= '0;
      abscissa_q <= '0;
    end else if (shift) begin
      sample_q   <= sample_in;
      abscissa_q <= abscissa_in;
    end
  end

  // product of the entry as it stands after this shift
  always_ff @(posedge clk) begin
    if (shift) begin
      product <= mult;
    end
  end

endmodule

`default_nettype wire

[src/fca_sum_tree.sv]
// two-level registered adder tree over the cell products
`timescale 1ns / 1ps
`default_nettype none

module fca_sum_tree import fca_pkg::*; (
  input  logic                     clk,
  input  tree_ctrl_t               ctrl,
  input  logic signed [PROD_W-1:0] prod [TREE_LEAVES],
  output logic signed [FILT_W-1:0] sum
);

  logic signed [MID_W-1:0]  part      [TREE_GROUPS];
  logic signed [MID_W-1:0]  part_next [TREE_GROUPS];
  logic signed [FILT_W-1:0] sum_next;

  always_comb begin
    for (int g = 0; g < TREE_GROUPS; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        part_next[g] = part_next[g] + MID_W'(prod[g*GROUP_SIZE + k]);
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int g = 0; g < TREE_GROUPS; g++) begin
      sum_next = sum_next + FILT_W'(part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_mid) begin
      part <= part_next;
    end
    if (ctrl.ld_out) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

[src/fca_checker.sv]
// port checker for the fir filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module fca_checker import fca_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [FILT_W-1:0] out_filtered,
  input logic signed [ABSC_W-1:0] out_center,
  input logic                     cfg_ready
);

  // nothing is left in flight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // with the output register empty the whole pipeline can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("sample request refused while no result is pending");

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered) && $stable(out_center))
    else $error("stalled result changed or dropped");

  // register writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("register write channel not ready");

endmodule

bind fir_filter_with_centered_abscissa fca_checker u_fca_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_filtered (results.filtered),
  .out_center   (results.center_abscissa),
  .cfg_ready    (cfg.ready)
);

`default_nettype wire
